// File: hdl/ip_address_to_text_macros.svh
// Assertion macros used by the ip_address_to_text module.
`ifndef IP_ADDRESS_TO_TEXT_MACROS_SVH
`define IP_ADDRESS_TO_TEXT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IATT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("iatt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IATT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("iatt assertion failed");

`endif

// File: hdl/iatt_pkg.sv
`timescale 1ns / 1ps

package iatt_pkg;

    localparam logic [1:0] FAM_V4 = 2'd0;
    localparam logic [1:0] FAM_V6 = 2'd1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SP_ZERO  = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_UNSUP    = 2'd3;

    localparam logic [7:0] V4_MIN_SPACE = 8'd16;
    localparam logic [7:0] V6_MIN_SPACE = 8'd46;

    typedef struct packed {
        logic [1:0]  family;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [7:0]  space;
    } t_in;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic [1:0] status;
    } t_out;

    typedef enum logic [3:0] {
        S_ENTRY, S_FAM, S_V4H, S_V4T, S_V4O, S_V4DOT, S_SCAN, S_GTOP,
        S_GSEP, S_D3, S_D2, S_D1, S_D0, S_COMP, S_COMP2, S_ERR
    } t_step;

    typedef enum logic [2:0] {
        CH_ERR, CH_HUND, CH_TENS, CH_ONES, CH_DOT, CH_COLON, CH_NIB
    } t_chr;

    typedef enum logic [2:0] {
        L_NO, L_YES, L_OCT3, L_GRP7, L_RUNEND
    } t_last;

    typedef enum logic [3:0] {
        C_NEVER, C_ALWAYS, C_ERR, C_V6, C_LT100, C_LT10, C_SKIPSEP,
        C_NIBZ, C_AT_BEST, C_SCAN_MORE
    } t_cond;

    typedef enum logic [1:0] {
        I_HOLD, I_INC, I_ADD_BEST
    } t_idx_op;

    typedef struct packed {
        logic    emit;
        t_chr    chr;
        logic [1:0] nib;
        t_last   last;
        t_cond   cond;
        logic    skip;
        t_step   tgt;
        t_idx_op idx_op;
        logic    scan;
    } t_ctrl;

    typedef struct packed {
        logic err;
        logic v6;
        logic lt100;
        logic lt10;
        logic skip_sep;
        logic nib_zero;
        logic at_best;
        logic scan_more;
    } t_flags;

    typedef struct packed {
        logic busy;
        logic go;
        logic finish;
    } t_seq_in;

    typedef struct packed {
        logic emit;
        logic taken;
    } t_act;

    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        w = '{emit: 1'b0, chr: CH_ERR, nib: 2'd0, last: L_NO, cond: C_NEVER,
              skip: 1'b0, tgt: S_ENTRY, idx_op: I_HOLD, scan: 1'b0};
        unique case (step)
            S_ENTRY: begin
                w.cond = C_ERR;
                w.tgt  = S_ERR;
            end
            S_FAM: begin
                w.cond = C_V6;
                w.tgt  = S_SCAN;
            end
            S_V4H: begin
                w.emit = 1'b1; w.chr = CH_HUND;
                w.cond = C_LT100; w.skip = 1'b1; w.tgt = S_V4T;
            end
            S_V4T: begin
                w.emit = 1'b1; w.chr = CH_TENS;
                w.cond = C_LT10; w.skip = 1'b1; w.tgt = S_V4O;
            end
            S_V4O: begin
                w.emit = 1'b1; w.chr = CH_ONES; w.last = L_OCT3;
            end
            S_V4DOT: begin
                w.emit = 1'b1; w.chr = CH_DOT; w.idx_op = I_INC;
                w.cond = C_ALWAYS; w.tgt = S_V4H;
            end
            S_SCAN: begin
                w.scan = 1'b1; w.idx_op = I_INC;
                w.cond = C_SCAN_MORE; w.tgt = S_SCAN;
            end
            S_GTOP: begin
                w.cond = C_AT_BEST;
                w.tgt  = S_COMP;
            end
            S_GSEP: begin
                w.emit = 1'b1; w.chr = CH_COLON;
                w.cond = C_SKIPSEP; w.skip = 1'b1; w.tgt = S_D3;
            end
            S_D3: begin
                w.emit = 1'b1; w.chr = CH_NIB; w.nib = 2'd3;
                w.cond = C_NIBZ; w.skip = 1'b1; w.tgt = S_D2;
            end
            S_D2: begin
                w.emit = 1'b1; w.chr = CH_NIB; w.nib = 2'd2;
                w.cond = C_NIBZ; w.skip = 1'b1; w.tgt = S_D1;
            end
            S_D1: begin
                w.emit = 1'b1; w.chr = CH_NIB; w.nib = 2'd1;
                w.cond = C_NIBZ; w.skip = 1'b1; w.tgt = S_D0;
            end
            S_D0: begin
                w.emit = 1'b1; w.chr = CH_NIB; w.nib = 2'd0; w.last = L_GRP7;
                w.idx_op = I_INC; w.cond = C_ALWAYS; w.tgt = S_GTOP;
            end
            S_COMP: begin
                w.emit = 1'b1; w.chr = CH_COLON;
            end
            S_COMP2: begin
                w.emit = 1'b1; w.chr = CH_COLON; w.last = L_RUNEND;
                w.idx_op = I_ADD_BEST; w.cond = C_ALWAYS; w.tgt = S_GTOP;
            end
            S_ERR: begin
                w.emit = 1'b1; w.chr = CH_ERR; w.last = L_YES;
            end
        endcase
        return w;
    endfunction

    // Decimal digits of an octet as {hundreds, tens, ones}.
    function automatic logic [11:0] dec_digits(input logic [7:0] v);
        logic [3:0] h;
        logic [3:0] t;
        logic [6:0] r;
        logic [6:0] o;
        if (v >= 8'd200) begin
            h = 4'd2;
            r = 7'(v - 8'd200);
        end else if (v >= 8'd100) begin
            h = 4'd1;
            r = 7'(v - 8'd100);
        end else begin
            h = 4'd0;
            r = v[6:0];
        end
        t = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (r >= 7'(k * 10)) t = 4'(k);
        end
        o = r - 7'(t) * 7'd10;
        return {h, t, o[3:0]};
    endfunction

endpackage

// File: hdl/iatt_seq.sv
`timescale 1ns / 1ps

module iatt_seq
    import iatt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_seq_in i_ctl,
    input  t_flags  i_flags,
    output t_ctrl   o_ctrl,
    output t_act    o_act
);

    t_step r_pc;
    t_step n_pc;
    t_ctrl w;
    logic  taken;

    assign w      = ucode(r_pc);
    assign o_ctrl = w;

    always_comb begin
        unique case (w.cond)
            C_NEVER:     taken = 1'b0;
            C_ALWAYS:    taken = 1'b1;
            C_ERR:       taken = i_flags.err;
            C_V6:        taken = i_flags.v6;
            C_LT100:     taken = i_flags.lt100;
            C_LT10:      taken = i_flags.lt10;
            C_SKIPSEP:   taken = i_flags.skip_sep;
            C_NIBZ:      taken = i_flags.nib_zero;
            C_AT_BEST:   taken = i_flags.at_best;
            C_SCAN_MORE: taken = i_flags.scan_more;
            default:     taken = 1'b0;
        endcase
    end

    // A taken jump on a skip step drops that step's character.
    assign o_act.taken = taken;
    assign o_act.emit  = w.emit && !(taken && w.skip);

    always_comb begin
        n_pc = r_pc;
        if (i_ctl.finish) begin
            n_pc = S_ENTRY;
        end else if (i_ctl.busy && i_ctl.go) begin
            n_pc = taken ? w.tgt : t_step'(r_pc + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_ENTRY;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// File: hdl/ip_address_to_text.sv
`timescale 1ns / 1ps
// One microcode step per cycle; a character step waits while the output register is full.
// Error: 2 steps; S_ENTRY jumps to S_ERR, which registers the error result.
// IPv4: 17 steps (2 setup, 3 per octet, 3 dots); a skipped leading digit step emits nothing.
// IPv6: 2 steps, an 8-step zero-run scan, then 6 steps per group or 3 for the run (58 at most).
// The next transaction is taken in the cycle after the last character is registered.
// Reset (synchronous, active low) clears the step counter, busy flag and output valid.

module ip_address_to_text
    import iatt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    `include "ip_address_to_text_macros.svh"

    logic         r_busy;
    logic [1:0]   r_fam;
    logic [127:0] r_addr;
    logic [1:0]   r_err;
    logic [2:0]   r_idx;
    logic         r_prev_colon;
    logic         r_run_in;
    logic [2:0]   r_run_start;
    logic [3:0]   r_run_len;
    logic [2:0]   r_best_start;
    logic [3:0]   r_run_max;
    logic         r_out_valid;
    t_out         r_out;

    t_ctrl   ctrl;
    t_act    act;
    t_flags  flags;
    t_seq_in seq_in;

    logic [1:0]  n_err;
    logic        accept;
    logic        go;
    logic        last_now;
    logic [15:0] grp;
    logic [7:0]  oct;
    logic [11:0] digs;
    logic [3:0]  nibv;
    logic [7:0]  chr;
    logic [3:0]  run_end;
    logic [3:0]  nl;
    logic [2:0]  ns;

    iatt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (seq_in),
        .i_flags (flags),
        .o_ctrl  (ctrl),
        .o_act   (act)
    );

    assign o_in_ready  = !r_busy && i_rst_n;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        if (i_in.space == 8'd0) begin
            n_err = ST_SP_ZERO;
        end else if (i_in.family == FAM_V4) begin
            n_err = (i_in.space < V4_MIN_SPACE) ? ST_NO_SPACE : ST_OK;
        end else if (i_in.family == FAM_V6) begin
            n_err = (i_in.space < V6_MIN_SPACE) ? ST_NO_SPACE : ST_OK;
        end else begin
            n_err = ST_UNSUP;
        end
    end

    assign grp     = r_addr[(3'd7 - r_idx) * 16 +: 16];
    assign oct     = r_addr[(2'd3 - r_idx[1:0]) * 8 +: 8];
    assign digs    = dec_digits(oct);
    assign nibv    = grp[ctrl.nib * 4 +: 4];
    assign run_end = {1'b0, r_idx} + r_run_max;

    always_comb begin
        flags.err       = (r_err != ST_OK);
        flags.v6        = (r_fam == FAM_V6);
        flags.lt100     = (oct < 8'd100);
        flags.lt10      = (oct < 8'd10);
        flags.skip_sep  = (r_idx == 3'd0) || r_prev_colon;
        flags.at_best   = (r_run_max >= 4'd2) && (r_idx == r_best_start);
        flags.scan_more = (r_idx != 3'd7);
        case (ctrl.nib)
            2'd3:    flags.nib_zero = (grp[15:12] == 4'd0);
            2'd2:    flags.nib_zero = (grp[15:8] == 8'd0);
            2'd1:    flags.nib_zero = (grp[15:4] == 12'd0);
            default: flags.nib_zero = 1'b0;
        endcase
    end

    always_comb begin
        case (ctrl.chr)
            CH_HUND:  chr = 8'h30 + {4'd0, digs[11:8]};
            CH_TENS:  chr = 8'h30 + {4'd0, digs[7:4]};
            CH_ONES:  chr = 8'h30 + {4'd0, digs[3:0]};
            CH_DOT:   chr = 8'h2e;
            CH_COLON: chr = 8'h3a;
            CH_NIB:   chr = (nibv < 4'd10) ? (8'h30 + {4'd0, nibv})
                                           : (8'h61 + {4'd0, nibv} - 8'd10);
            default:  chr = 8'h00;
        endcase
        case (ctrl.last)
            L_YES:    last_now = 1'b1;
            L_OCT3:   last_now = (r_idx[1:0] == 2'd3);
            L_GRP7:   last_now = (r_idx == 3'd7);
            L_RUNEND: last_now = (run_end == 4'd8);
            default:  last_now = 1'b0;
        endcase
    end

    // Hold the step while its character has no room in the output register.
    assign go = !act.emit || !r_out_valid || i_out_ready;

    assign seq_in.busy   = r_busy;
    assign seq_in.go     = go;
    assign seq_in.finish = r_busy && go && act.emit && last_now;

    assign nl = r_run_in ? (r_run_len + 4'd1) : 4'd1;
    assign ns = r_run_in ? r_run_start : r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_busy       <= 1'b1;
                r_fam        <= i_in.family;
                r_addr       <= {i_in.address_high, i_in.address_low};
                r_err        <= n_err;
                r_idx        <= 3'd0;
                r_prev_colon <= 1'b0;
                r_run_in     <= 1'b0;
                r_run_start  <= 3'd0;
                r_run_len    <= 4'd0;
                r_best_start <= 3'd0;
                r_run_max    <= 4'd0;
            end else if (r_busy && go) begin
                if (act.emit) begin
                    r_out_valid     <= 1'b1;
                    r_out.character <= chr;
                    r_out.last      <= last_now;
                    r_out.status    <= (ctrl.chr == CH_ERR) ? r_err : ST_OK;
                    r_prev_colon    <= (ctrl.chr == CH_COLON);
                    if (last_now) begin
                        r_busy <= 1'b0;
                    end
                end
                if (ctrl.scan) begin
                    if (grp == 16'd0) begin
                        r_run_in    <= 1'b1;
                        r_run_start <= ns;
                        r_run_len   <= nl;
                        if (nl > r_run_max) begin
                            r_best_start <= ns;
                            r_run_max    <= nl;
                        end
                    end else begin
                        r_run_in <= 1'b0;
                    end
                end
                case (ctrl.idx_op)
                    I_INC:      r_idx <= r_idx + 3'd1;
                    I_ADD_BEST: r_idx <= r_idx + r_run_max[2:0];
                    default:    r_idx <= r_idx;
                endcase
            end
        end
    end

    `IATT_ASSERT_IMPL(a_err_result_form, i_clk, i_rst_n,
        r_out_valid && (r_out.status != ST_OK),
        (r_out.character == 8'h00) && r_out.last)
    `IATT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        accept, r_busy)
    `IATT_ASSERT_IMPL(a_best_run_bounded, i_clk, i_rst_n,
        r_busy, ({1'b0, r_best_start} + r_run_max) <= 4'd8)

endmodule

// File: bench/ip_address_to_text_tb.sv
`timescale 1ns / 1ps

module ip_address_to_text_tb;
    import iatt_pkg::*;

    localparam logic [1:0] FAM_UNSUP_LO = 2'd2;
    localparam logic [1:0] FAM_UNSUP_HI = 2'd3;
    localparam logic [7:0] ASC_ZERO     = "0";
    localparam logic [7:0] ASC_A        = "a";
    localparam logic [7:0] ASC_COLON    = ":";
    localparam logic [7:0] ASC_DOT      = ".";
    localparam int         MAX_WAIT     = 18;
    localparam int         PHASE_SETTLE = 8;
    localparam int         END_SETTLE   = 64;
    localparam int         CYCLE_LIMIT  = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    t_out expected_chars[$];
    int   mismatches = 0;
    int   chars_seen = 0;
    int   cycles = 0;
    bit   no_idle = 1'b0;

    ip_address_to_text i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int draw_wait();
        if (no_idle)
            return 0;
        case ($urandom_range(0, 3))
            0, 1:    return 0;
            2:       return $urandom_range(1, 3);
            default: return $urandom_range(0, MAX_WAIT);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch: %s", msg);
    endtask

    // Expected text of one request, one character per result.
    task automatic predict_text(input t_in req);
        logic [7:0]  txt[$];
        logic [15:0] grp[8];
        logic [7:0]  oct;
        logic [3:0]  nib;
        logic [1:0]  code;
        int          best_start;
        int          top_len;
        int          run_start;
        int          run_len;
        int          i;
        bit          begun;
        t_out        r;

        if (req.space == 8'd0)
            code = ST_SP_ZERO;
        else if (req.family == FAM_V4)
            code = (req.space < V4_MIN_SPACE) ? ST_NO_SPACE : ST_OK;
        else if (req.family == FAM_V6)
            code = (req.space < V6_MIN_SPACE) ? ST_NO_SPACE : ST_OK;
        else
            code = ST_UNSUP;

        if (code != ST_OK) begin
            r.character = 8'd0;
            r.last = 1'b1;
            r.status = code;
            expected_chars.push_back(r);
            return;
        end

        if (req.family == FAM_V4) begin
            for (int o = 3; o >= 0; o--) begin
                oct = req.address_low[8*o +: 8];
                if (oct >= 8'd100)
                    txt.push_back(8'(ASC_ZERO + oct / 8'd100));
                if (oct >= 8'd10)
                    txt.push_back(8'(ASC_ZERO + (oct / 8'd10) % 8'd10));
                txt.push_back(8'(ASC_ZERO + oct % 8'd10));
                if (o > 0)
                    txt.push_back(ASC_DOT);
            end
        end else begin
            for (i = 0; i < 4; i++) begin
                grp[i]     = req.address_high[63 - 16*i -: 16];
                grp[i + 4] = req.address_low[63 - 16*i -: 16];
            end
            // Keep the first of equally long zero runs.
            best_start = -1;
            top_len = 0;
            run_start = -1;
            run_len = 0;
            for (i = 0; i < 8; i++) begin
                if (grp[i] == 16'd0) begin
                    if (run_start < 0) begin
                        run_start = i;
                        run_len = 0;
                    end
                    run_len++;
                    if (run_len > top_len) begin
                        best_start = run_start;
                        top_len = run_len;
                    end
                end else begin
                    run_start = -1;
                end
            end
            if (top_len < 2)
                best_start = -1;
            i = 0;
            while (i < 8) begin
                if (i == best_start) begin
                    txt.push_back(ASC_COLON);
                    txt.push_back(ASC_COLON);
                    i += top_len;
                end else begin
                    if (i > 0 && txt[$] != ASC_COLON)
                        txt.push_back(ASC_COLON);
                    begun = 1'b0;
                    for (int sh = 3; sh >= 0; sh--) begin
                        nib = grp[i][4*sh +: 4];
                        if (nib != 4'd0 || begun || sh == 0) begin
                            txt.push_back(nib < 4'd10 ? 8'(ASC_ZERO + nib)
                                                      : 8'(ASC_A + nib - 4'd10));
                            begun = 1'b1;
                        end
                    end
                    i++;
                end
            end
        end

        foreach (txt[k]) begin
            r.character = txt[k];
            r.last = (k == txt.size() - 1);
            r.status = ST_OK;
            expected_chars.push_back(r);
        end
    endtask

    // Hold the request until the handshake completes, then predict its text.
    task automatic send_request(input t_in req);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_text(req);
    endtask

    task automatic wait_text_done(input int settle);
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic t_in make_req(input logic [1:0] fam, input logic [63:0] hi,
                                     input logic [63:0] lo, input logic [7:0] sp);
        t_in req;
        req.family = fam;
        req.address_high = hi;
        req.address_low = lo;
        req.space = sp;
        return req;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] rand_group();
        case ($urandom_range(0, 5))
            0, 1, 2: return 16'd0;
            3:       return 16'($urandom_range(1, 15)) << (4 * $urandom_range(0, 3));
            default: return 16'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    function automatic t_in rand_request();
        t_in        req;
        logic [63:0] hi;
        logic [63:0] lo;
        int          pick;
        pick = $urandom_range(0, 99);
        req = make_req(FAM_V4, rand64(), rand64(), 8'($urandom_range(0, 255)));
        if (pick < 45) begin
            for (int g = 0; g < 4; g++) begin
                hi[63 - 16*g -: 16] = rand_group();
                lo[63 - 16*g -: 16] = rand_group();
            end
            if ($urandom_range(0, 7) == 0) begin
                hi = rand64();
                lo = rand64();
            end
            req = make_req(FAM_V6, hi, lo, 8'($urandom_range(V6_MIN_SPACE, 255)));
        end else if (pick < 80) begin
            req.space = 8'($urandom_range(V4_MIN_SPACE, 255));
        end else if (pick < 88) begin
            req.family = $urandom_range(0, 1) ? FAM_V6 : FAM_V4;
            req.space = 8'($urandom_range(1, (req.family == FAM_V6) ? V6_MIN_SPACE - 1
                                                                     : V4_MIN_SPACE - 1));
        end else if (pick < 94) begin
            req.family = 2'($urandom_range(0, 3));
            req.space = 8'd0;
        end else begin
            req.family = 2'($urandom_range(FAM_UNSUP_LO, FAM_UNSUP_HI));
            if (req.space == 8'd0)
                req.space = 8'd255;
        end
        return req;
    endfunction

    task automatic test_bad_requests();
        send_request(make_req(FAM_V4, '0, 64'h0a00_0001, 8'd0));
        send_request(make_req(FAM_V6, '1, '1, 8'd0));
        send_request(make_req(FAM_UNSUP_HI, '0, '0, 8'd0));
        send_request(make_req(FAM_V4, '0, 64'hc0a8_0101, V4_MIN_SPACE - 8'd1));
        send_request(make_req(FAM_V6, '0, 64'd1, V6_MIN_SPACE - 8'd1));
        send_request(make_req(FAM_UNSUP_LO, '1, '1, 8'd255));
        send_request(make_req(FAM_UNSUP_HI, '0, '0, 8'd100));
    endtask

    task automatic test_dotted_decimal();
        send_request(make_req(FAM_V4, '0, 64'h0000_0000, V4_MIN_SPACE));
        send_request(make_req(FAM_V4, '0, 64'hffff_ffff, 8'd255));
        // Ignore the upper address bits.
        send_request(make_req(FAM_V4, '1, 64'hdead_beef_0a64_09c7, 8'd200));
        send_request(make_req(FAM_V4, 64'h1234_5678_9abc_def0, 64'h0102_0304, 8'd16));
        send_request(make_req(FAM_V4, '0, 64'h630a_6409, 8'd17));
    endtask

    task automatic test_hex_groups();
        send_request(make_req(FAM_V6, '0, '0, V6_MIN_SPACE));
        send_request(make_req(FAM_V6, '1, '1, 8'd255));
        send_request(make_req(FAM_V6, 64'h0001_0000_0000_0000, '0, 8'd255));
        send_request(make_req(FAM_V6, '0, 64'd1, 8'd255));
        send_request(make_req(FAM_V6, 64'h2001_0db8_0000_0000, 64'h0001_0000_0000_0001,
                              8'd255));
        send_request(make_req(FAM_V6, 64'h0001_0000_0002_0003, 64'h0004_0005_0006_0007,
                              8'd47));
        send_request(make_req(FAM_V6, 64'h0000_0000_0001_0000, 64'h0000_0000_0002_0000,
                              8'd128));
        send_request(make_req(FAM_V6, 64'h0abc_00f0_000f_a000, 64'h1234_5678_9abc_def0,
                              8'd255));
        send_request(make_req(FAM_V6, 64'h1111_2222_3333_4444, 64'h5555_6666_0000_0000,
                              8'd99));
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (40) send_request(rand_request());
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < 220; n++) begin
            if (n % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_request(rand_request());
            if (n == 120)
                wait_text_done(PHASE_SETTLE);
        end
        no_idle = 1'b0;
    endtask

    // Drain the text stream and compare each character with the oldest expectation.
    initial begin
        int   stall;
        t_out want;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_ready));
            chars_seen++;
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("result %0d unexpected: char %h last %b status %0d",
                                          chars_seen, o_out.character, o_out.last,
                                          o_out.status));
            end else begin
                want = expected_chars.pop_front();
                if (o_out.character !== want.character)
                    report_mismatch($sformatf("result %0d char %h, want %h", chars_seen,
                                              o_out.character, want.character));
                if (o_out.last !== want.last)
                    report_mismatch($sformatf("result %0d last %b, want %b", chars_seen,
                                              o_out.last, want.last));
                if (o_out.status !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d", chars_seen,
                                              o_out.status, want.status));
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_bad_requests();
        test_dotted_decimal();
        wait_text_done(PHASE_SETTLE);
        test_hex_groups();
        wait_text_done(PHASE_SETTLE);
        test_back_to_back();
        wait_text_done(PHASE_SETTLE);
        test_random_traffic();
        wait_text_done(END_SETTLE);
        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_chars.size()));
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/iatt_pkg.sv
hdl/iatt_seq.sv
hdl/ip_address_to_text.sv
bench/ip_address_to_text_tb.sv
